@@ rtl/vfre_pkg.sv @@
package vfre_pkg;

   // Common fixed-point widths (signed Q16.16)
   localparam int unsigned DATA_W = 32;
   localparam int unsigned WINDOW_DEPTH_DEF = 5;

   // Event codes on req_type
   typedef enum logic [1:0] {
      EV_ODOM  = 2'd0,
      EV_ACCEL = 2'd1,
      EV_CMD   = 2'd2,
      EV_TICK  = 2'd3
   } event_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_MASS_SURGE  = 3'd0,
      CSR_MASS_SWAY   = 3'd1,
      CSR_MASS_HEAVE  = 3'd2,
      CSR_QDAMP_SURGE = 3'd3,
      CSR_QDAMP_SWAY  = 3'd4,
      CSR_QDAMP_HEAVE = 3'd5,
      CSR_NET_WEIGHT  = 3'd6,
      CSR_UNUSED      = 3'd7
   } csr_index_type;

   // Register reset values
   localparam logic signed [31:0] MASS_SURGE_RST  = 32'sd917504;
   localparam logic signed [31:0] MASS_SWAY_RST   = 32'sd1959526;
   localparam logic signed [31:0] MASS_HEAVE_RST  = 32'sd1618739;
   localparam logic signed [31:0] QDAMP_SURGE_RST = -32'sd2291139;
   localparam logic signed [31:0] QDAMP_SWAY_RST  = -32'sd6766592;
   localparam logic signed [31:0] QDAMP_HEAVE_RST = -32'sd4864737;
   localparam logic signed [31:0] NET_WEIGHT_RST  = -32'sd186909;

   // Linear damping coefficients
   localparam logic signed [31:0] LIN_DAMP_SURGE = -32'sd5898;
   localparam logic signed [31:0] LIN_DAMP_SWAY  = -32'sd17039;
   localparam logic signed [31:0] LIN_DAMP_HEAVE = -32'sd12452;

   localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

   // Saturate a 48-bit value to 32 bits
   function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
      logic signed [31:0] r;
      if (x > 48'sh0000_7fff_ffff) r = S32_MAX;
      else if (x < -48'sh0000_8000_0000) r = S32_MIN;
      else r = x[31:0];
      return r;
   endfunction

   // Saturating absolute value
   function automatic logic signed [31:0] sabs(input logic signed [31:0] x);
      logic signed [31:0] r;
      if (x == S32_MIN) r = S32_MAX;
      else if (x < 0) r = -x;
      else r = x;
      return r;
   endfunction

endpackage

@@ rtl/vehicle_force_residual_estimator.sv @@
// Channel  | Ports                         | Transfer
// ---------+-------------------------------+----------------------------
// request  | req_valid/req_ready, req_*    | one event per transfer
// response | rsp_valid/rsp_ready, rsp_*    | one estimate per tick event
// config   | csr_we, csr_index, csr_wdata  | one register write per cycle
//
// Odometry and command events are latched while idle. An acceleration event
// updates the window and running sums, then divides each axis sum in the
// bit-serial divider (SUM_W = 32 + clog2(WINDOW_DEPTH+1) + 1). A tick computes
// its products one after another in the shared bit-serial multiplier.
// Reset is synchronous and clears the window count, sums and latches.
// A finished estimate waits in the response register; further events are
// accepted meanwhile, a following tick is computed and then holds the input
// off until that register is free.
module vehicle_force_residual_estimator
   import vfre_pkg::*;
#(
   parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic signed [31:0]  req_vel_surge,
   input  logic signed [31:0]  req_vel_sway,
   input  logic signed [31:0]  req_vel_heave,
   input  logic signed [31:0]  req_yaw_rate,
   input  logic signed [31:0]  req_acc_x,
   input  logic signed [31:0]  req_acc_y,
   input  logic signed [31:0]  req_acc_z,
   input  logic signed [31:0]  req_cmd_force_x,
   input  logic signed [31:0]  req_cmd_force_y,
   input  logic signed [31:0]  req_cmd_force_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_dist_x,
   output logic signed [31:0]  rsp_dist_y,
   output logic signed [31:0]  rsp_dist_z,
   output logic signed [31:0]  rsp_echo_vel_surge,
   output logic signed [31:0]  rsp_echo_vel_sway,
   output logic signed [31:0]  rsp_echo_vel_heave,
   output logic signed [31:0]  rsp_echo_cmd_x,
   output logic signed [31:0]  rsp_echo_cmd_y,
   output logic signed [31:0]  rsp_echo_cmd_z,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int unsigned FILL_W = $clog2(WINDOW_DEPTH + 1);
   localparam int unsigned SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int unsigned SUM_W  = DATA_W + FILL_W + 1;
   localparam int unsigned DCNT_W = $clog2(SUM_W);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_DEPTH);
   localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(SUM_W - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_ACC_RD, ST_ACC_SUM, ST_DIV_LD, ST_DIV_RUN, ST_DIV_END,
      ST_MUL_LD, ST_MUL_RUN, ST_MUL_ACC, ST_OUT
   } state_type;

   typedef enum logic [3:0] {
      S_X_ACC, S_X_COR1, S_X_COR2, S_X_DMP1, S_X_DMP2,
      S_Y_ACC, S_Y_COR1, S_Y_COR2, S_Y_DMP1, S_Y_DMP2,
      S_Z_ACC, S_Z_DMP1, S_Z_DMP2
   } step_type;

   // Configuration registers
   logic signed [31:0] mass_surge_ff, mass_sway_ff, mass_heave_ff;
   logic signed [31:0] qd_surge_ff, qd_sway_ff, qd_heave_ff, net_weight_ff;

   // Latched state
   logic signed [31:0] mot_ff [4];
   logic signed [31:0] cmd_ff [3];
   logic signed [31:0] filt_ff [3];
   logic signed [SUM_W-1:0] sum_ff [3];
   logic signed [31:0] new_ff [3];
   logic signed [31:0] old_ff [3];
   logic [FILL_W-1:0] fill_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [1:0] axis_ff;

   // Sample window
   logic [31:0] win_mem [3][WINDOW_DEPTH];

   state_type state_ff;
   step_type step_ff;

   // Divider
   logic [SUM_W-1:0] dq_ff;
   logic [FILL_W:0] dr_ff;
   logic dneg_ff;
   logic [DCNT_W-1:0] dcnt_ff;

   // Multiplier
   logic signed [31:0] ma_ff;
   logic [31:0] mb_ff;
   logic signed [32:0] mhi_ff;
   logic [31:0] mlo_ff;
   logic [4:0] mcnt_ff;

   logic signed [31:0] tmp_ff;
   logic signed [34:0] f_ff;
   logic signed [31:0] dx_ff, dy_ff, dz_ff;

   logic rsp_valid_ff;
   logic signed [31:0] o_dx_ff, o_dy_ff, o_dz_ff;
   logic signed [31:0] o_u_ff, o_v_ff, o_w_ff, o_cx_ff, o_cy_ff, o_cz_ff;

   logic req_fire;
   assign req_ready = (state_ff == ST_IDLE) && !reset;
   assign req_fire  = req_valid && req_ready;

   // Operand selection for the shared multiplier
   logic signed [31:0] op_a, op_b;
   always_comb begin
      op_a = mass_surge_ff;
      op_b = filt_ff[0];
      case (step_ff)
         S_X_ACC:  begin op_a = mass_surge_ff; op_b = filt_ff[0]; end
         S_X_COR1: begin op_a = mass_sway_ff;  op_b = mot_ff[1]; end
         S_X_COR2: begin op_a = tmp_ff;        op_b = mot_ff[3]; end
         S_X_DMP1: begin op_a = qd_surge_ff;   op_b = sabs(mot_ff[0]); end
         S_X_DMP2: begin
            op_a = sat48(48'(LIN_DAMP_SURGE) + 48'(tmp_ff)); op_b = mot_ff[0];
         end
         S_Y_ACC:  begin op_a = mass_sway_ff;  op_b = filt_ff[1]; end
         S_Y_COR1: begin op_a = mass_surge_ff; op_b = mot_ff[0]; end
         S_Y_COR2: begin op_a = tmp_ff;        op_b = mot_ff[3]; end
         S_Y_DMP1: begin op_a = qd_sway_ff;    op_b = sabs(mot_ff[1]); end
         S_Y_DMP2: begin
            op_a = sat48(48'(LIN_DAMP_SWAY) + 48'(tmp_ff)); op_b = mot_ff[1];
         end
         S_Z_ACC:  begin op_a = mass_heave_ff; op_b = filt_ff[2]; end
         S_Z_DMP1: begin op_a = qd_heave_ff;   op_b = sabs(mot_ff[2]); end
         S_Z_DMP2: begin
            op_a = sat48(48'(LIN_DAMP_HEAVE) + 48'(tmp_ff)); op_b = mot_ff[2];
         end
         default: ;
      endcase
   end

   // One multiplier bit: add (or subtract on the sign bit) and shift right
   logic signed [33:0] mul_add;
   logic signed [33:0] mul_sum;
   always_comb begin
      if (!mb_ff[0]) mul_add = '0;
      else if (mcnt_ff == 5'd31) mul_add = -34'(ma_ff);
      else mul_add = 34'(ma_ff);
      mul_sum = 34'(mhi_ff) + mul_add;
   end

   // Floored Q16.16 product, saturated
   logic [63:0] prod;
   logic signed [31:0] pq;
   assign prod = {mhi_ff[31:0], mlo_ff};
   assign pq   = sat48(prod[63:16]);

   // End-of-axis force sums
   logic signed [35:0] fx_end, fy_end, fz_end;
   assign fx_end = 36'(f_ff) - 36'(pq) - 36'(cmd_ff[0]);
   assign fy_end = 36'(f_ff) - 36'(pq) - 36'(cmd_ff[1]);
   assign fz_end = 36'(f_ff) - 36'(pq) - 36'(cmd_ff[2]) - 36'(net_weight_ff);

   // Restoring divider step
   logic [FILL_W:0] div_r2;
   logic div_ge;
   assign div_r2 = {dr_ff[FILL_W-1:0], dq_ff[SUM_W-1]};
   assign div_ge = (div_r2 >= {1'b0, fill_ff});

   // Sample window storage, read before write at the current slot
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC_RD) begin
         for (int a = 0; a < 3; a++) begin
            old_ff[a] <= win_mem[a][slot_ff];
            win_mem[a][slot_ff] <= new_ff[a];
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mass_surge_ff <= MASS_SURGE_RST;
         mass_sway_ff  <= MASS_SWAY_RST;
         mass_heave_ff <= MASS_HEAVE_RST;
         qd_surge_ff   <= QDAMP_SURGE_RST;
         qd_sway_ff    <= QDAMP_SWAY_RST;
         qd_heave_ff   <= QDAMP_HEAVE_RST;
         net_weight_ff <= NET_WEIGHT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MASS_SURGE:  mass_surge_ff <= csr_wdata;
            CSR_MASS_SWAY:   mass_sway_ff  <= csr_wdata;
            CSR_MASS_HEAVE:  mass_heave_ff <= csr_wdata;
            CSR_QDAMP_SURGE: qd_surge_ff   <= csr_wdata;
            CSR_QDAMP_SWAY:  qd_sway_ff    <= csr_wdata;
            CSR_QDAMP_HEAVE: qd_heave_ff   <= csr_wdata;
            CSR_NET_WEIGHT:  net_weight_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= S_X_ACC;
         fill_ff      <= '0;
         slot_ff      <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) mot_ff[i] <= '0;
         for (int i = 0; i < 3; i++) begin
            cmd_ff[i]  <= '0;
            filt_ff[i] <= '0;
            sum_ff[i]  <= '0;
         end
      end else begin
         // response register is reloaded in ST_OUT itself
         if (rsp_valid_ff && rsp_ready && state_ff != ST_OUT) rsp_valid_ff <= 1'b0;

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (event_type'(req_type))
                     EV_ODOM: begin
                        mot_ff[0] <= req_vel_surge;
                        mot_ff[1] <= req_vel_sway;
                        mot_ff[2] <= req_vel_heave;
                        mot_ff[3] <= req_yaw_rate;
                     end
                     EV_ACCEL: begin
                        new_ff[0] <= req_acc_x;
                        new_ff[1] <= req_acc_y;
                        new_ff[2] <= req_acc_z;
                        state_ff  <= ST_ACC_RD;
                     end
                     EV_CMD: begin
                        cmd_ff[0] <= req_cmd_force_x;
                        cmd_ff[1] <= req_cmd_force_y;
                        cmd_ff[2] <= req_cmd_force_z;
                     end
                     EV_TICK: begin
                        step_ff  <= S_X_ACC;
                        state_ff <= ST_MUL_LD;
                     end
                     default: ;
                  endcase
               end
            end

            ST_ACC_RD: state_ff <= ST_ACC_SUM;

            // Running sum: drop the overwritten sample once the window is full
            ST_ACC_SUM: begin
               for (int a = 0; a < 3; a++) begin
                  if (fill_ff == FILL_FULL)
                     sum_ff[a] <= sum_ff[a] + SUM_W'(new_ff[a]) - SUM_W'(old_ff[a]);
                  else
                     sum_ff[a] <= sum_ff[a] + SUM_W'(new_ff[a]);
               end
               if (fill_ff != FILL_FULL) fill_ff <= fill_ff + 1'b1;
               slot_ff  <= (slot_ff == SLOT_LAST) ? '0 : slot_ff + 1'b1;
               axis_ff  <= '0;
               state_ff <= ST_DIV_LD;
            end

            ST_DIV_LD: begin
               dneg_ff  <= sum_ff[axis_ff][SUM_W-1];
               dq_ff    <= sum_ff[axis_ff][SUM_W-1] ? -sum_ff[axis_ff] : sum_ff[axis_ff];
               dr_ff    <= '0;
               dcnt_ff  <= '0;
               state_ff <= ST_DIV_RUN;
            end

            ST_DIV_RUN: begin
               dr_ff   <= div_ge ? div_r2 - {1'b0, fill_ff} : div_r2;
               dq_ff   <= {dq_ff[SUM_W-2:0], div_ge};
               dcnt_ff <= dcnt_ff + 1'b1;
               if (dcnt_ff == DCNT_LAST) state_ff <= ST_DIV_END;
            end

            ST_DIV_END: begin
               filt_ff[axis_ff] <= dneg_ff ? -dq_ff[31:0] : dq_ff[31:0];
               if (axis_ff == 2'd2) state_ff <= ST_IDLE;
               else begin
                  axis_ff  <= axis_ff + 1'b1;
                  state_ff <= ST_DIV_LD;
               end
            end

            ST_MUL_LD: begin
               ma_ff    <= op_a;
               mb_ff    <= op_b;
               mhi_ff   <= '0;
               mlo_ff   <= '0;
               mcnt_ff  <= '0;
               state_ff <= ST_MUL_RUN;
            end

            ST_MUL_RUN: begin
               mhi_ff  <= mul_sum[33:1];
               mlo_ff  <= {mul_sum[0], mlo_ff[31:1]};
               mb_ff   <= {1'b0, mb_ff[31:1]};
               mcnt_ff <= mcnt_ff + 1'b1;
               if (mcnt_ff == 5'd31) state_ff <= ST_MUL_ACC;
            end

            // Fold the product into the force sum, or keep it as an intermediate operand
            ST_MUL_ACC: begin
               state_ff <= ST_MUL_LD;
               step_ff  <= step_type'(step_ff + 1'b1);
               case (step_ff)
                  S_X_ACC, S_Y_ACC, S_Z_ACC: f_ff <= 35'(pq);
                  S_X_COR2: f_ff <= f_ff - 35'(pq);
                  S_Y_COR2: f_ff <= f_ff + 35'(pq);
                  S_X_DMP2: dx_ff <= sat48(48'(fx_end));
                  S_Y_DMP2: dy_ff <= sat48(48'(fy_end));
                  S_Z_DMP2: begin
                     dz_ff    <= sat48(48'(fz_end));
                     state_ff <= ST_OUT;
                  end
                  default: tmp_ff <= pq;
               endcase
            end

            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  o_dx_ff  <= dx_ff;
                  o_dy_ff  <= dy_ff;
                  o_dz_ff  <= dz_ff;
                  o_u_ff   <= mot_ff[0];
                  o_v_ff   <= mot_ff[1];
                  o_w_ff   <= mot_ff[2];
                  o_cx_ff  <= cmd_ff[0];
                  o_cy_ff  <= cmd_ff[1];
                  o_cz_ff  <= cmd_ff[2];
                  state_ff <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dist_x         = o_dx_ff;
   assign rsp_dist_y         = o_dy_ff;
   assign rsp_dist_z         = o_dz_ff;
   assign rsp_echo_vel_surge = o_u_ff;
   assign rsp_echo_vel_sway  = o_v_ff;
   assign rsp_echo_vel_heave = o_w_ff;
   assign rsp_echo_cmd_x     = o_cx_ff;
   assign rsp_echo_cmd_y     = o_cy_ff;
   assign rsp_echo_cmd_z     = o_cz_ff;

endmodule
